[rtl/core/satq_pkg.sv]
// satq_pkg: shared types and constants of the sorted alarm timer queue
// word layouts of both channels, controller/datapath command and status structs
// no dependencies
package satq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TagBitsDef    = 8;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned TagFieldW     = 8;

  typedef enum logic {
    KindAdd  = 1'b0,
    KindTick = 1'b1
  } kind_e;

  typedef enum logic {
    ResAdd  = 1'b0,
    ResFire = 1'b1
  } res_kind_e;

  typedef enum logic {
    AddOk   = 1'b0,
    AddFull = 1'b1
  } add_status_e;

  typedef struct packed {
    kind_e                kind;
    logic [TimeW-1:0]     delay_seconds;
    logic [TagFieldW-1:0] tag;
  } in_word_t;

  typedef struct packed {
    res_kind_e            result_kind;
    add_status_e          add_status;
    logic [TagFieldW-1:0] fired_tag;
    logic [TimeW-1:0]     fired_deadline;
    logic                 last_result;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic add_start;   // capture add word, compute deadline
    logic tick_start;  // advance time, clear fire bookkeeping
    logic rd_en;       // read queue memory
    logic rd_fire;     // read at head
    logic rd_off2;     // read two below insert position, else one below
    logic wr_shift;    // move read entry up into insert position
    logic wr_new;      // write new entry at insert position
    logic pop;         // take head entry as pending alarm
    logic emit_add;    // load add result into output register
    logic emit_pend;   // load pending alarm into output register
    logic emit_last;   // last flag for pending alarm
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic count_zero;
    logic pos_zero;
    logic pos_one;
    logic later;       // read entry deadline after new deadline
    logic due;         // read entry deadline at or before time now
    logic out_free;
    logic k_max;
    logic pend;
  } dp_status_t;

  typedef enum logic [6:0] {
    StIdle  = 7'b000_0001,
    StAddRd = 7'b000_0010,
    StAddCm = 7'b000_0100,
    StAddRs = 7'b000_1000,
    StFirRd = 7'b001_0000,
    StFirCk = 7'b010_0000,
    StFirLs = 7'b100_0000
  } state_e;

endpackage

[rtl/core/sorted_alarm_timer_queue.sv]
// sorted_alarm_timer_queue: top level of the deadline sorted alarm queue
// instantiates satq_ctrl and satq_datapath; uses satq_pkg
//
// usage
//   input channel: one word per add or tick, taken when in_valid_i is high and
//   in_stall_o is low; in_stall_o stays high while a word is being worked on
//   output channel: result words, taken when out_valid_o is high and
//   out_stall_i is low; an add gives one word, a tick one per due alarm up to
//   MaxResults (earliest first, ties in arrival order, last flagged) or none
// sequencing
//   add: into an empty queue the new entry is written directly; else queued
//   entries with a later deadline shift up one place, one entry a cycle through
//   the single read and single write port of the queue memory, and the new
//   entry takes the freed place
//   tick: due alarms leave from the head until an entry not yet due ends the
//   walk; each head read is compared in the cycle after it, on the registered
//   memory data; a full queue answers an add with AddFull and drops it
// reset
//   time, queue fill and output valid clear at once; no clearing pass
// stall
//   a stalled result word holds; the block waits with the next result
//   until the output register frees, then carries on
module sorted_alarm_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = satq_pkg::QueueDepthDef,
  parameter int unsigned TAG_BITS    = satq_pkg::TagBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  satq_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output satq_pkg::out_word_t  out_word_o
);
  import satq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: add walk, fire loop, result hand-off
  satq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_word_i.kind),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // queue memory, time counter and output register
  satq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // never insert into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_new |-> !status.full)
    else $error("insert into full queue");

  // never pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !status.count_zero)
    else $error("pop from empty queue");

  // never overwrite a result word that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_add || cmd.emit_pend) |-> status.out_free)
    else $error("result word overwritten");

  // the block is busy in the cycle after it accepts a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepted word");

endmodule

[rtl/core/satq_ctrl.sv]
// satq_ctrl: sequencing state machine of the sorted alarm timer queue
// issues datapath commands from datapath status; uses satq_pkg
module satq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  satq_pkg::kind_e       in_kind_i,
  output logic                  in_stall_o,
  input  satq_pkg::dp_status_t  status_i,
  output satq_pkg::dp_cmd_t     cmd_o
);
  import satq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_kind_i == KindAdd) begin
            cmd_o.add_start = 1'b1;
            state_d = status_i.full ? StAddRs : StAddRd;
          end else begin
            cmd_o.tick_start = 1'b1;
            state_d = StFirRd;
          end
        end
      end
      StAddRd: begin
        if (status_i.pos_zero) begin
          cmd_o.wr_new = 1'b1;
          state_d = StAddRs;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = StAddCm;
        end
      end
      StAddCm: begin
        if (status_i.later) begin
          cmd_o.wr_shift = 1'b1;
          if (status_i.pos_one) begin
            state_d = StAddRd;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_off2 = 1'b1;
          end
        end else begin
          cmd_o.wr_new = 1'b1;
          state_d = StAddRs;
        end
      end
      StAddRs: begin
        if (status_i.out_free) begin
          cmd_o.emit_add = 1'b1;
          state_d = StIdle;
        end
      end
      StFirRd: begin
        if (status_i.count_zero || status_i.k_max) begin
          state_d = StFirLs;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_fire = 1'b1;
          state_d = StFirCk;
        end
      end
      StFirCk: begin
        if (!status_i.due) begin
          state_d = StFirLs;
        end else if (!status_i.pend || status_i.out_free) begin
          cmd_o.emit_pend = status_i.pend;
          cmd_o.pop       = 1'b1;
          state_d = StFirRd;
        end
      end
      StFirLs: begin
        if (!status_i.pend) begin
          state_d = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.emit_pend = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/satq_datapath.sv]
// satq_datapath: circular queue memory, time counter, insert walk and output register
// driven by satq_ctrl commands; uses satq_pkg
module satq_datapath #(
  parameter int unsigned QUEUE_DEPTH = satq_pkg::QueueDepthDef,
  parameter int unsigned TAG_BITS    = satq_pkg::TagBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  satq_pkg::in_word_t    in_word_i,
  input  satq_pkg::dp_cmd_t     cmd_i,
  output satq_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output satq_pkg::out_word_t   out_word_o
);
  import satq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SB = (TAG_BITS < TagFieldW) ? TAG_BITS : TagFieldW;
  localparam int unsigned DW = TimeW + SB;
  localparam int unsigned KW = $clog2(MaxResults + 1);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [DW-1:0]    mem [QUEUE_DEPTH];
  logic [DW-1:0]    rd_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [KW-1:0]    k_q, k_d;
  logic [TimeW-1:0] time_q, time_d;
  logic             drop_q, drop_d;
  logic             pend_q, pend_d;
  logic [TimeW-1:0] new_dl_q;
  logic [SB-1:0]    new_tag_q;
  logic [TimeW-1:0] pend_dl_q;
  logic [SB-1:0]    pend_tag_q;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q;

  logic [TimeW:0]   dl_sum;
  logic [CW-1:0]    rd_off;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [DW-1:0]    wr_data;
  logic [TimeW-1:0] rd_dl;
  logic             out_free;

  assign rd_dl   = rd_q[DW-1 -: TimeW];
  assign dl_sum  = {1'b0, time_q} + {1'b0, in_word_i.delay_seconds};
  assign rd_off  = cmd_i.rd_fire ? '0 : (pos_q - (cmd_i.rd_off2 ? CW'(2) : CW'(1)));
  assign rd_addr = wrap_add(head_q, rd_off[AW-1:0]);
  assign wr_addr = wrap_add(head_q, pos_q[AW-1:0]);
  assign wr_data = cmd_i.wr_new ? {new_dl_q, new_tag_q} : rd_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // queue memory: one read, one write port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem[rd_addr];
    if (cmd_i.wr_shift || cmd_i.wr_new) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_start) begin
      new_dl_q  <= dl_sum[TimeW] ? '1 : dl_sum[TimeW-1:0];
      new_tag_q <= in_word_i.tag[SB-1:0];
    end
    if (cmd_i.pop) begin
      pend_dl_q  <= rd_dl;
      pend_tag_q <= rd_q[SB-1:0];
    end
    if (cmd_i.emit_add) begin
      out_q.result_kind    <= ResAdd;
      out_q.add_status     <= drop_q ? AddFull : AddOk;
      out_q.fired_tag      <= TagFieldW'(new_tag_q);
      out_q.fired_deadline <= new_dl_q;
      out_q.last_result    <= 1'b1;
    end else if (cmd_i.emit_pend) begin
      out_q.result_kind    <= ResFire;
      out_q.add_status     <= AddOk;
      out_q.fired_tag      <= TagFieldW'(pend_tag_q);
      out_q.fired_deadline <= pend_dl_q;
      out_q.last_result    <= cmd_i.emit_last;
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    k_d     = k_q;
    time_d  = time_q;
    drop_d  = drop_q;
    pend_d  = pend_q;
    if (cmd_i.add_start) begin
      pos_d  = count_q;
      drop_d = status_o.full;
    end
    if (cmd_i.tick_start) begin
      time_d = (time_q == '1) ? time_q : time_q + TimeW'(1);
      k_d    = '0;
      pend_d = 1'b0;
    end
    if (cmd_i.wr_shift) pos_d = pos_q - CW'(1);
    if (cmd_i.wr_new) count_d = count_q + CW'(1);
    if (cmd_i.pop) begin
      head_d  = wrap_add(head_q, AW'(1));
      count_d = count_q - CW'(1);
      k_d     = k_q + KW'(1);
      pend_d  = 1'b1;
    end
    out_valid_d = cmd_i.emit_add || cmd_i.emit_pend || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      time_q      <= '0;
      drop_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      time_q      <= time_d;
      drop_q      <= drop_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.full       = (count_q == CW'(QUEUE_DEPTH));
  assign status_o.count_zero = (count_q == '0);
  assign status_o.pos_zero   = (pos_q == '0);
  assign status_o.pos_one    = (pos_q == CW'(1));
  assign status_o.later      = (rd_dl > new_dl_q);
  assign status_o.due        = (rd_dl <= time_q);
  assign status_o.out_free   = out_free;
  assign status_o.k_max      = (k_q == KW'(MaxResults));
  assign status_o.pend       = pend_q;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
